### rtl/cbmm_pkg.sv
`timescale 1ns / 1ps
// cbmm_pkg: shared types, codes and constants for the cartridge bank memory map unit
// no dependencies; imported by every module of the block

package cbmm_pkg;

    // rom bank bits used for the switchable window, bits 0 to 6
    localparam int unsigned ROM_BANK_BITS = 7;
    localparam logic [6:0]  ROM_BANK_MASK = 7'((1 << ROM_BANK_BITS) - 1);

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // cartridge controller types, the unused code behaves as mbc1
    localparam logic [1:0] CT_MBC1 = 2'd0;
    localparam logic [1:0] CT_MBC2 = 2'd1;
    localparam logic [1:0] CT_MBC3 = 2'd2;

    // configuration register indexes
    localparam logic CFG_CART_TYPE = 1'b0;
    localparam logic CFG_BOOT_ROM  = 1'b1;

    // target regions
    localparam logic [3:0] RGN_BOOT = 4'd0;
    localparam logic [3:0] RGN_ROM  = 4'd1;
    localparam logic [3:0] RGN_VRAM = 4'd2;
    localparam logic [3:0] RGN_CRAM = 4'd3;
    localparam logic [3:0] RGN_RTC  = 4'd4;
    localparam logic [3:0] RGN_WRAM = 4'd5;
    localparam logic [3:0] RGN_OAM  = 4'd6;
    localparam logic [3:0] RGN_IO   = 4'd7;
    localparam logic [3:0] RGN_HRAM = 4'd8;
    localparam logic [3:0] RGN_NONE = 4'd9;

    // io addresses with special write handling
    localparam logic [15:0] ADDR_DIV = 16'hFF04;
    localparam logic [15:0] ADDR_TAC = 16'hFF07;
    localparam logic [15:0] ADDR_LY  = 16'hFF44;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  region;
        logic [20:0] offset;
        logic        store;
        logic [7:0]  store_value;
        logic        timer_reload_valid;
        logic [10:0] timer_reload;
    } t_out_word;

    typedef struct packed {
        logic [6:0] rom_bank;
        logic [1:0] ram_bank;
        logic       ram_enable;
        logic       banking_mode;
        logic       rtc_selected;
        logic [2:0] rtc_index;
        logic [1:0] timer_select;
    } t_bank_state;

    typedef struct packed {
        logic [1:0] cart_type;
        logic       boot_rom_mapped;
    } t_cfg;

    function automatic logic [10:0] timer_reload_of(input logic [1:0] sel);
        logic [10:0] val;
        case (sel)
            2'd0:    val = 11'd1024;
            2'd1:    val = 11'd16;
            2'd2:    val = 11'd64;
            default: val = 11'd256;
        endcase
        return val;
    endfunction

endpackage

### rtl/cbmm_regs.sv
`timescale 1ns / 1ps
// cbmm_regs: configuration registers and bank controller state registers
// depends on cbmm_pkg

module cbmm_regs import cbmm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_update,
    input  t_bank_state i_next_state,
    output t_bank_state o_state,
    output t_cfg        o_cfg
);

    t_bank_state r_state;
    t_cfg        r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.rom_bank     <= 7'd1;
            r_state.ram_bank     <= 2'd0;
            r_state.ram_enable   <= 1'b0;
            r_state.banking_mode <= 1'b0;
            r_state.rtc_selected <= 1'b0;
            r_state.rtc_index    <= 3'd0;
            r_state.timer_select <= 2'd0;
        end else if (i_update) begin
            r_state <= i_next_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cart_type       <= CT_MBC1;
            r_cfg.boot_rom_mapped <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CART_TYPE: r_cfg.cart_type       <= i_cfg_data;
                CFG_BOOT_ROM:  r_cfg.boot_rom_mapped <= i_cfg_data[0];
                default:       r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign o_state = r_state;
    assign o_cfg   = r_cfg;

endmodule

### rtl/cbmm_decode.sv
`timescale 1ns / 1ps
// cbmm_decode: decodes one bus word to region and offset, computes next controller state
// depends on cbmm_pkg

module cbmm_decode import cbmm_pkg::*; (
    input  t_in_word    i_word,
    input  t_bank_state i_state,
    input  t_cfg        i_cfg,
    output t_out_word   o_word,
    output t_bank_state o_next_state
);

    logic        is_mbc2;
    logic        is_mbc3;
    logic        is_mbc1;
    logic        wr;
    logic [15:0] a;
    logic [7:0]  v;
    logic [12:0] rel;
    logic [6:0]  bank;
    t_bank_state ns;
    t_out_word   res;

    assign is_mbc2 = (i_cfg.cart_type == CT_MBC2);
    assign is_mbc3 = (i_cfg.cart_type == CT_MBC3);
    assign is_mbc1 = !is_mbc2 && !is_mbc3;
    assign wr      = (i_word.kind == KIND_WRITE);
    assign a       = i_word.address;
    assign v       = i_word.write_data;
    assign rel     = a[12:0];
    assign bank    = i_state.rom_bank & ROM_BANK_MASK;

    always_comb begin
        ns  = i_state;
        res = '0;
        res.region = RGN_NONE;

        if (a[15] == 1'b0) begin
            if (wr) begin
                // controller register write
                unique case (a[14:13])
                    2'd0: begin
                        if (!(is_mbc2 && a[8])) begin
                            ns.ram_enable = (v[3:0] == 4'hA);
                        end
                    end
                    2'd1: begin
                        if (is_mbc1) begin
                            ns.rom_bank = {i_state.rom_bank[6:5],
                                           (v[4:0] == 5'd0) ? 5'd1 : v[4:0]};
                        end else if (is_mbc2) begin
                            ns.rom_bank = {i_state.rom_bank[6:4], v[3:0]};
                            if ({i_state.rom_bank[6:4], v[3:0]} == 7'd0) begin
                                ns.rom_bank = 7'd1;
                            end
                        end else begin
                            ns.rom_bank = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];
                        end
                    end
                    2'd2: begin
                        if (is_mbc1) begin
                            if (!i_state.banking_mode) begin
                                ns.rom_bank = {v[1:0], i_state.rom_bank[4:0]};
                                if ({v[1:0], i_state.rom_bank[4:0]} == 7'd0) begin
                                    ns.rom_bank = 7'd1;
                                end
                            end else begin
                                ns.ram_bank = v[1:0];
                            end
                        end else if (is_mbc3) begin
                            if (v <= 8'd3) begin
                                ns.ram_bank     = v[1:0];
                                ns.rtc_selected = 1'b0;
                            end else if (v >= 8'd8 && v <= 8'd12) begin
                                ns.rtc_index    = 3'(v - 8'd8);
                                ns.rtc_selected = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (is_mbc1) begin
                            ns.banking_mode = v[0];
                            if (v[0]) begin
                                ns.ram_bank = 2'd0;
                            end
                        end
                    end
                endcase
            end else if (a[15:8] == 8'h00 && i_cfg.boot_rom_mapped) begin
                res.region = RGN_BOOT;
                res.offset = {5'd0, a};
            end else if (a[14] == 1'b0) begin
                res.region = RGN_ROM;
                res.offset = {5'd0, a};
            end else begin
                res.region = RGN_ROM;
                res.offset = {bank, a[13:0]};
            end
        end else if (a[15:13] == 3'b100) begin
            res.region = RGN_VRAM;
            res.offset = {8'd0, rel};
            res.store  = wr;
        end else if (a[15:13] == 3'b101) begin
            // cart ram window
            if (is_mbc2) begin
                if (rel[12:9] == 4'd0) begin
                    res.region = RGN_CRAM;
                    res.offset = {8'd0, rel};
                end
            end else if (is_mbc3) begin
                if (i_state.rtc_selected) begin
                    res.region = RGN_RTC;
                    res.offset = {18'd0, i_state.rtc_index};
                end else begin
                    res.region = RGN_CRAM;
                    res.offset = {6'd0, i_state.ram_bank, rel};
                end
            end else begin
                res.region = RGN_CRAM;
                res.offset = i_state.banking_mode ? {6'd0, i_state.ram_bank, rel}
                                                  : {8'd0, rel};
            end
            res.store = wr && i_state.ram_enable && (res.region != RGN_NONE);
        end else if (a < 16'hFE00) begin
            res.region = RGN_WRAM;
            res.offset = {8'd0, rel};
            res.store  = wr;
        end else if (a < 16'hFEA0) begin
            res.region = RGN_OAM;
            res.offset = {13'd0, a[7:0]};
            res.store  = wr;
        end else if (a[15:8] == 8'hFE) begin
            res.region = RGN_NONE;
        end else if (a[7]) begin
            res.region = RGN_HRAM;
            res.offset = {14'd0, a[6:0]};
            res.store  = wr;
        end else begin
            res.region = RGN_IO;
            res.offset = {14'd0, a[6:0]};
            res.store  = wr;
            if (wr && a == ADDR_TAC) begin
                if (v[1:0] != i_state.timer_select) begin
                    res.timer_reload_valid = 1'b1;
                    res.timer_reload       = timer_reload_of(v[1:0]);
                end
                ns.timer_select = v[1:0];
            end
        end

        // stored byte: divider and line counter are cleared, mbc2 ram is a nibble
        if (res.store) begin
            if (res.region == RGN_IO && (a == ADDR_DIV || a == ADDR_LY)) begin
                res.store_value = 8'd0;
            end else if (res.region == RGN_CRAM && is_mbc2) begin
                res.store_value = {4'd0, v[3:0]};
            end else begin
                res.store_value = v;
            end
        end
    end

    assign o_word       = res;
    assign o_next_state = ns;

endmodule

### rtl/cartridge_bank_memory_map_unit.sv
`timescale 1ns / 1ps
// cartridge_bank_memory_map_unit: top level, input register, decode and result register
// depends on cbmm_pkg, cbmm_regs, cbmm_decode
//
//   channel   direction  handshake             word
//   in        input      i_in_valid/o_in_stall   t_in_word (kind, address, write_data)
//   out       output     o_out_valid/i_out_stall t_out_word (region .. timer_reload)
//   cfg       input      i_cfg_valid/o_cfg_ready index 0 cart_type, 1 boot_rom_mapped
//
// one word per cycle sustained while the output is not stalled
// a word passes the input register, the decode and then the result register
// controller state moves at the edge where a word enters the result register
// a stall on the output holds both registers and stalls the input once full
// reset: synchronous, active low, clears valid bits, state and configuration

module cartridge_bank_memory_map_unit import cbmm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [1:0] i_cfg_data
);

    logic        r_in_valid;
    t_in_word    r_in;
    logic        r_out_valid;
    t_out_word   r_out;
    logic        advance;
    logic        in_accept;
    t_bank_state state;
    t_bank_state next_state;
    t_cfg        cfg;
    t_out_word   dec_word;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= dec_word;
        end
    end

    cbmm_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_update     (advance),
        .i_next_state (next_state),
        .o_state      (state),
        .o_cfg        (cfg)
    );

    cbmm_decode u_decode (
        .i_word       (r_in),
        .i_state      (state),
        .i_cfg        (cfg),
        .o_word       (dec_word),
        .o_next_state (next_state)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
